>>> rtl/bom_pkg.sv
// ----------------------------------------------------------------------------
// bom_pkg
// Shared constants and types of the best offset mismatch search block.
// ----------------------------------------------------------------------------
package bom_pkg;

    // Store depths and the widths that follow from them
    localparam int TEXT_DEPTH    = 256;
    localparam int PATTERN_DEPTH = 256;
    localparam int TEXT_AW       = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int PAT_AW        = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int TCNT_W        = $clog2(TEXT_DEPTH + 1);
    localparam int PCNT_W        = $clog2(PATTERN_DEPTH + 1);
    localparam int HCNT_W        = PCNT_W;

    // Item fields
    localparam int CODE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int OUT_W     = 9;
    localparam int TDATA_W   = 32;
    localparam int RATIO_W   = 20;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = RATIO_W + HCNT_W;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd1;
    localparam logic [RATIO_W-1:0]   RATIO_RESET = 20'd6554;

    // Base codes
    localparam logic [CODE_W-1:0] LAST_BASE   = 8'd3;
    localparam logic [CODE_W-1:0] FIRST_OTHER = 8'd4;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

endpackage

>>> rtl/bom_ram.sv
// ----------------------------------------------------------------------------
// bom_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/best_offset_mismatch_search.sv
// ----------------------------------------------------------------------------
// best_offset_mismatch_search
// Ungapped sliding alignment of a pattern over a text, best offset search.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per handshake: tuser holds the command, tdata the
//   base code. Text and pattern loads give no result; a load past the store
//   depth is dropped. A run command starts the search and tready stays low
//   until it is done. The run reads one text and one pattern entry per cycle
//   from the two RAMs, over min(text_len - off, pattern_len) positions at
//   each offset, then drains the pipeline. An empty text or pattern skips
//   the walk.
//   The result (offset, matches, mismatches) goes to an output register on
//   m_axis. While the receiver stalls, loads are still taken; a second run
//   waits at its end until the first result is taken.
//   The cfg channel is always ready and writes mismatch_ratio (index 0) or
//   n_policy (index 1); write it only while the block is idle.
//   Reset empties both stores and loads the register defaults. No clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module best_offset_mismatch_search
    import bom_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CODE_W-1:0]    s_axis_tdata,   // [7:0] base_code
    input  logic [CMD_W-1:0]     s_axis_tuser,   // [1:0] cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [8:0] best_offset, [17:9] match_count,
                                                 // [26:18] mismatch_count, [31:27] zero
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RATIO_W-1:0]   i_cfg_data
);

    t_state              r_state, n_state;
    logic [TCNT_W-1:0]   r_tc;
    logic [PCNT_W-1:0]   r_pc;
    logic [RATIO_W-1:0]  r_ratio;
    logic                r_policy;

    // Issue counters
    logic [TEXT_AW-1:0]  r_off;
    logic [PAT_AW-1:0]   r_k;

    // Compare stage
    logic                r_v1, r_l1;
    logic [TEXT_AW-1:0]  r_off1;
    logic [HCNT_W-1:0]   r_acc_h, r_acc_m;

    // Offset score stage
    logic                r_e_v;
    logic [HCNT_W-1:0]   r_e_h, r_e_m;
    logic [TEXT_AW-1:0]  r_e_off;

    // Product stage
    logic                r_p_v;
    logic [PROD_W-1:0]   r_prod;
    logic [HCNT_W-1:0]   r_p_h, r_p_m;
    logic [TEXT_AW-1:0]  r_p_off;

    // Best so far and output register
    logic [TCNT_W-1:0]   r_best_off;
    logic [HCNT_W-1:0]   r_best_h, r_best_m;
    logic                r_out_valid;
    logic [TDATA_W-1:0]  r_out_data;

    logic                in_acc, run_start, drained, out_free, finish;
    logic                t_end, p_end, last_pos, o_end;
    logic                text_we, pat_we;
    logic [TEXT_AW-1:0]  text_raddr;
    logic [CODE_W-1:0]   text_rdata, pat_rdata;
    logic                hit, miss, qualify;
    logic [HCNT_W-1:0]   sum_h, sum_m;

    // Handshakes
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign run_start     = in_acc && (s_axis_tuser == CMD_RUN);
    assign text_we       = in_acc && (s_axis_tuser == CMD_TEXT) &&
                           (r_tc < TCNT_W'(TEXT_DEPTH));
    assign pat_we        = in_acc && (s_axis_tuser == CMD_PATTERN) &&
                           (r_pc < PCNT_W'(PATTERN_DEPTH));
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Position walk: end of overlap at text end or pattern end
    assign t_end      = (TCNT_W'(r_off) + TCNT_W'(r_k) + TCNT_W'(1)) == r_tc;
    assign p_end      = (PCNT_W'(r_k) + PCNT_W'(1)) == r_pc;
    assign last_pos   = t_end || p_end;
    assign o_end      = (TCNT_W'(r_off) + TCNT_W'(1)) == r_tc;
    assign text_raddr = TEXT_AW'(TCNT_W'(r_off) + TCNT_W'(r_k));

    assign drained  = !r_v1 && !r_e_v && !r_p_v;
    assign out_free = !r_out_valid || m_axis_tready;
    assign finish   = (r_state == ST_DRAIN) && drained && out_free;

    bom_ram #(.WIDTH(CODE_W), .DEPTH(TEXT_DEPTH), .AW(TEXT_AW)) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (text_we),
        .i_waddr (r_tc[TEXT_AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (text_raddr),
        .o_rdata (text_rdata)
    );

    bom_ram #(.WIDTH(CODE_W), .DEPTH(PATTERN_DEPTH), .AW(PAT_AW)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (r_pc[PAT_AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_k),
        .o_rdata (pat_rdata)
    );

    // Classify one position by the N policy
    always_comb begin
        if (r_policy) begin
            hit  = (text_rdata == pat_rdata) && (pat_rdata < FIRST_OTHER);
            miss = !hit;
        end else begin
            hit  = (text_rdata <= LAST_BASE) && (text_rdata == pat_rdata);
            miss = (text_rdata <= LAST_BASE) && (text_rdata != pat_rdata);
        end
        sum_h = r_acc_h + HCNT_W'(hit);
        sum_m = r_acc_m + HCNT_W'(miss);
    end

    // Better than best so far, at least one match, and within the mismatch ratio
    assign qualify = ((r_p_h > r_best_h) || ((r_p_h == r_best_h) && (r_p_m < r_best_m))) &&
                     (r_p_h != '0) && ((PROD_W'(r_p_m) << FRAC_BITS) <= r_prod);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (run_start) begin
                    n_state = ((r_tc == '0) || (r_pc == '0)) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_pos && o_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, counts and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tc        <= '0;
            r_pc        <= '0;
            r_ratio     <= RATIO_RESET;
            r_policy    <= 1'b0;
            r_v1        <= 1'b0;
            r_e_v       <= 1'b0;
            r_p_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == ST_RUN);
            r_e_v   <= r_v1 && r_l1;
            r_p_v   <= r_e_v;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_RATIO) begin
                    r_ratio <= i_cfg_data;
                end else if (i_cfg_index == CFG_POLICY) begin
                    r_policy <= i_cfg_data[0];
                end
            end

            if (text_we) begin
                r_tc <= r_tc + TCNT_W'(1);
            end
            if (pat_we) begin
                r_pc <= r_pc + PCNT_W'(1);
            end

            // Hand over the result and empty both stores
            if (finish) begin
                r_out_valid <= 1'b1;
                r_tc        <= '0;
                r_pc        <= '0;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: walk, compare, score, product, select
    always_ff @(posedge i_clk) begin
        // Advance the position walk
        if (run_start) begin
            r_off <= '0;
            r_k   <= '0;
        end else if (r_state == ST_RUN) begin
            if (last_pos) begin
                r_k <= '0;
                if (!o_end) begin
                    r_off <= r_off + TEXT_AW'(1);
                end
            end else begin
                r_k <= r_k + PAT_AW'(1);
            end
        end
        r_l1   <= last_pos;
        r_off1 <= r_off;

        // Accumulate one offset
        if (run_start) begin
            r_acc_h <= '0;
            r_acc_m <= '0;
        end else if (r_v1) begin
            if (r_l1) begin
                r_acc_h <= '0;
                r_acc_m <= '0;
            end else begin
                r_acc_h <= sum_h;
                r_acc_m <= sum_m;
            end
        end
        r_e_h   <= sum_h;
        r_e_m   <= sum_m;
        r_e_off <= r_off1;

        // Ratio bound for this offset
        r_prod  <= PROD_W'(r_ratio) * PROD_W'(r_e_h);
        r_p_h   <= r_e_h;
        r_p_m   <= r_e_m;
        r_p_off <= r_e_off;

        // Keep the first best offset
        if (run_start) begin
            r_best_off <= r_tc;
            r_best_h   <= '0;
            r_best_m   <= '0;
        end else if (r_p_v && qualify) begin
            r_best_off <= TCNT_W'(r_p_off);
            r_best_h   <= r_p_h;
            r_best_m   <= r_p_m;
        end

        if (finish) begin
            r_out_data <= TDATA_W'({OUT_W'(r_best_m), OUT_W'(r_best_h), OUT_W'(r_best_off)});
        end
    end

endmodule

>>> rtl/bom_chk.sv
// ----------------------------------------------------------------------------
// bom_chk
// Port level checks of the best offset mismatch search block.
// ----------------------------------------------------------------------------
module bom_chk
    import bom_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [CODE_W-1:0]    s_axis_tdata,
    input logic [CMD_W-1:0]     s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [TDATA_W-1:0]   m_axis_tdata,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [RATIO_W-1:0]   i_cfg_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // After a run item is taken, the input is closed
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_RUN) |=> !s_axis_tready)
        else $error("input open right after a run item");

    // Loads never close the input
    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_RUN) |=> s_axis_tready)
        else $error("input closed after a load item");

    // A new result appears only at the end of a run
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a run");

    // Padding bits above the three nine-bit fields stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1:3*OUT_W] == '0))
        else $error("padding bits set in result");

endmodule

bind best_offset_mismatch_search bom_chk u_bom_chk (.*);
